>>> hdl/hrhp_pkg.sv
// hrhp_pkg: types, codes and helper functions of the http response head parser
// used by hrhp_core and http_response_head_parser_top, depends on nothing
package hrhp_pkg;

   // width of the status code accumulator
   localparam int CODE_WIDTH = 32;
   // width of the status code field on the result channel
   localparam int CODE_OUT_WIDTH = 32;
   // line position counter saturates here
   localparam logic [3:0] POS_MAX = 4'd15;
   localparam logic [3:0] POS_VERSION = 4'd8;
   localparam logic [3:0] POS_CODE = 4'd9;

   // characters
   localparam logic [7:0] CH_LF = 8'h0a;
   localparam logic [7:0] CH_CR = 8'h0d;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   // error codes
   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_VERSION = 2'd1;
   localparam logic [1:0] ERR_MALFORMED = 2'd2;
   localparam logic [1:0] ERR_OVERFLOW = 2'd3;

   // status classes
   localparam logic [1:0] CLASS_OTHER = 2'd0;
   localparam logic [1:0] CLASS_SUCCESS = 2'd1;
   localparam logic [1:0] CLASS_REDIRECT = 2'd2;

   typedef enum logic [1:0] {
      PH_STATUS = 2'd0,
      PH_HEADERS = 2'd1,
      PH_BODY = 2'd2,
      PH_FAILED = 2'd3
   } phase_type;

   // how the digit run of the status code ended
   typedef enum logic [1:0] {
      TERM_SCAN = 2'd0,
      TERM_SPACE = 2'd1,
      TERM_BAD = 2'd2
   } term_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       new_response;
   } req_type;

   typedef struct packed {
      logic [1:0]                phase;
      logic                      body_valid;
      logic [7:0]                body_out;
      logic                      status_done;
      logic [CODE_OUT_WIDTH-1:0] status_code;
      logic [1:0]                status_class;
      logic                      headers_done;
      logic                      redirect_seen;
      logic [1:0]                error;
   } rsp_type;

   // byte at a prefix position matches HTTP/1.0 or HTTP/1.1
   function automatic logic prefix_match(input logic [2:0] pos, input logic [7:0] b);
      logic hit;
      begin
         case (pos)
            3'd0: hit = (b == 8'h48);
            3'd1: hit = (b == 8'h54);
            3'd2: hit = (b == 8'h54);
            3'd3: hit = (b == 8'h50);
            3'd4: hit = (b == 8'h2f);
            3'd5: hit = (b == 8'h31);
            3'd6: hit = (b == 8'h2e);
            default: hit = (b == 8'h30) || (b == 8'h31);
         endcase
         return hit;
      end
   endfunction

   // space or any of tab, lf, vt, ff, cr
   function automatic logic is_blank(input logic [7:0] b);
      return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
   endfunction

endpackage

>>> hdl/hrhp_core.sv
// hrhp_core: parser state and the single-pass decode of one byte
// depends on hrhp_pkg
module hrhp_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  hrhp_pkg::req_type item,
   output hrhp_pkg::rsp_type result
);

   localparam int AW = hrhp_pkg::CODE_WIDTH;

   hrhp_pkg::phase_type phase_ff, phase_in, cur_phase;
   logic [3:0]          pos_ff, pos_in, cur_pos;
   logic                prefix_ok_ff, prefix_ok_in, cur_prefix_ok;
   logic [AW-1:0]       acc_ff, acc_in, cur_acc;
   logic                digits_ff, digits_in, cur_digits;
   hrhp_pkg::term_type  term_ff, term_in, cur_term;
   logic                ovf_ff, ovf_in, cur_ovf;
   logic                starts_cr_ff, starts_cr_in, cur_starts_cr;
   logic [1:0]          class_ff, class_in, cur_class;

   logic [7:0]    b;
   logic [AW+3:0] acc_x10;
   logic [3:0]    digit;
   logic [1:0]    err;
   logic [63:0]   acc_ext;

   // error of a judged status line, bad prefix first, then malformed, then overflow
   function automatic logic [1:0] judge(input logic pok, input logic [3:0] pos,
                                        input hrhp_pkg::term_type term, input logic ovf);
      logic [1:0] e;
      begin
         if (!pok || (pos < hrhp_pkg::POS_VERSION))
            e = hrhp_pkg::ERR_VERSION;
         else if (term != hrhp_pkg::TERM_SPACE)
            e = hrhp_pkg::ERR_MALFORMED;
         else if (ovf)
            e = hrhp_pkg::ERR_OVERFLOW;
         else
            e = hrhp_pkg::ERR_NONE;
         return e;
      end
   endfunction

   // state seen by this byte, with a restart applied first
   always_comb begin
      if (item.new_response) begin
         cur_phase = hrhp_pkg::PH_STATUS;
         cur_pos = '0;
         cur_prefix_ok = 1'b1;
         cur_acc = '0;
         cur_digits = 1'b0;
         cur_term = hrhp_pkg::TERM_SCAN;
         cur_ovf = 1'b0;
         cur_starts_cr = 1'b0;
         cur_class = hrhp_pkg::CLASS_OTHER;
      end else begin
         cur_phase = phase_ff;
         cur_pos = pos_ff;
         cur_prefix_ok = prefix_ok_ff;
         cur_acc = acc_ff;
         cur_digits = digits_ff;
         cur_term = term_ff;
         cur_ovf = ovf_ff;
         cur_starts_cr = starts_cr_ff;
         cur_class = class_ff;
      end
   end

   // acc * 10 + digit, with four guard bits for the overflow test
   assign b = item.data_byte;
   assign digit = 4'(b - hrhp_pkg::CH_ZERO);
   assign acc_x10 = ({4'b0, cur_acc} << 3) + ({4'b0, cur_acc} << 1) + (AW+4)'(digit);

   // next state and result of this byte
   always_comb begin
      phase_in = cur_phase;
      pos_in = cur_pos;
      prefix_ok_in = cur_prefix_ok;
      acc_in = cur_acc;
      digits_in = cur_digits;
      term_in = cur_term;
      ovf_in = cur_ovf;
      starts_cr_in = cur_starts_cr;
      class_in = cur_class;
      result = '0;
      err = hrhp_pkg::ERR_NONE;

      unique case (cur_phase)
         hrhp_pkg::PH_STATUS: begin
            if (b == hrhp_pkg::CH_LF) begin
               result.status_done = 1'b1;
               err = judge(cur_prefix_ok, cur_pos, cur_term, cur_ovf);
               if (err != hrhp_pkg::ERR_NONE) begin
                  phase_in = hrhp_pkg::PH_FAILED;
               end else begin
                  // the value of the code picks the class: 200 to 299 success, 300 to 399 redirect
                  if ((cur_acc >= AW'(200)) && (cur_acc <= AW'(299)))
                     class_in = hrhp_pkg::CLASS_SUCCESS;
                  else if ((cur_acc >= AW'(300)) && (cur_acc <= AW'(399)))
                     class_in = hrhp_pkg::CLASS_REDIRECT;
                  else
                     class_in = hrhp_pkg::CLASS_OTHER;
                  phase_in = hrhp_pkg::PH_HEADERS;
                  pos_in = '0;
                  starts_cr_in = 1'b0;
               end
            end else begin
               if (cur_pos < hrhp_pkg::POS_VERSION) begin
                  if (!hrhp_pkg::prefix_match(cur_pos[2:0], b))
                     prefix_ok_in = 1'b0;
               end else if ((cur_pos >= hrhp_pkg::POS_CODE) &&
                            (cur_term == hrhp_pkg::TERM_SCAN)) begin
                  if ((b >= hrhp_pkg::CH_ZERO) && (b <= hrhp_pkg::CH_NINE)) begin
                     // saturate once the code no longer fits
                     if (cur_ovf || (acc_x10[AW+3:AW] != 4'd0)) begin
                        ovf_in = 1'b1;
                        acc_in = '1;
                     end else begin
                        acc_in = acc_x10[AW-1:0];
                     end
                     digits_in = 1'b1;
                  end else if (!cur_digits) begin
                     if (!hrhp_pkg::is_blank(b))
                        term_in = hrhp_pkg::TERM_BAD;
                  end else begin
                     term_in = (b == hrhp_pkg::CH_SPACE) ? hrhp_pkg::TERM_SPACE
                                                         : hrhp_pkg::TERM_BAD;
                  end
               end
               if (cur_pos < hrhp_pkg::POS_MAX)
                  pos_in = cur_pos + 4'd1;
            end
         end
         hrhp_pkg::PH_HEADERS: begin
            if (b == hrhp_pkg::CH_LF) begin
               // a line that opens with cr ends the head
               if ((cur_pos != 4'd0) && cur_starts_cr) begin
                  phase_in = hrhp_pkg::PH_BODY;
                  result.headers_done = 1'b1;
                  result.redirect_seen = (cur_class == hrhp_pkg::CLASS_REDIRECT);
               end
               pos_in = '0;
               starts_cr_in = 1'b0;
            end else begin
               if (cur_pos == 4'd0)
                  starts_cr_in = (b == hrhp_pkg::CH_CR);
               if (cur_pos < hrhp_pkg::POS_MAX)
                  pos_in = cur_pos + 4'd1;
            end
         end
         hrhp_pkg::PH_BODY: begin
            if (cur_class != hrhp_pkg::CLASS_REDIRECT) begin
               result.body_valid = 1'b1;
               result.body_out = b;
            end
         end
         hrhp_pkg::PH_FAILED: begin
         end
         default: begin
         end
      endcase

      // failed phase keeps reporting its error
      if (phase_in == hrhp_pkg::PH_FAILED)
         err = judge(prefix_ok_in, pos_in, term_in, ovf_in);

      result.phase = 2'(phase_in);
      result.error = err;
      if ((phase_in == hrhp_pkg::PH_HEADERS) || (phase_in == hrhp_pkg::PH_BODY)) begin
         result.status_code = acc_ext[hrhp_pkg::CODE_OUT_WIDTH-1:0];
         result.status_class = class_in;
      end
   end

   assign acc_ext = 64'(acc_in);

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hrhp_pkg::PH_STATUS;
         pos_ff <= '0;
         prefix_ok_ff <= 1'b1;
         acc_ff <= '0;
         digits_ff <= 1'b0;
         term_ff <= hrhp_pkg::TERM_SCAN;
         ovf_ff <= 1'b0;
         starts_cr_ff <= 1'b0;
         class_ff <= hrhp_pkg::CLASS_OTHER;
      end else if (step) begin
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         prefix_ok_ff <= prefix_ok_in;
         acc_ff <= acc_in;
         digits_ff <= digits_in;
         term_ff <= term_in;
         ovf_ff <= ovf_in;
         starts_cr_ff <= starts_cr_in;
         class_ff <= class_in;
      end
   end

endmodule

>>> hdl/http_response_head_parser_top.sv
// http_response_head_parser_top: input register, result register and parser core
// depends on hrhp_pkg and hrhp_core
//
// Takes one response byte per item and returns one result item per byte, in order.
// A new item is accepted every cycle while results are taken; each item passes an
// input register, is decoded by the parser core against the current parse state,
// and lands in the result register. The rate of one item per cycle is set by the
// core updating its parse state once per item. Raise new_response with the first
// byte of a response to restart at the status line.
module http_response_head_parser_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hrhp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hrhp_pkg::rsp_type rsp_data
);

   logic              s1_valid_ff, s1_valid_in;
   hrhp_pkg::req_type s1_data_ff, s1_data_in;
   logic              out_valid_ff, out_valid_in;
   hrhp_pkg::rsp_type out_data_ff, out_data_in;
   hrhp_pkg::rsp_type core_result;
   logic              advance;
   logic              req_accept;
   logic              rsp_accept;

   // handshake
   assign advance = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = out_valid_ff && !rsp_stall;

   // parser core
   hrhp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (s1_data_ff),
      .result (core_result)
   );

   // next values of both stages
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept)
         s1_valid_in = 1'b1;
      else if (advance)
         s1_valid_in = 1'b0;
      s1_data_in = req_accept ? req_data : s1_data_ff;

      out_valid_in = out_valid_ff;
      if (advance)
         out_valid_in = 1'b1;
      else if (rsp_accept)
         out_valid_in = 1'b0;
      out_data_in = advance ? core_result : out_data_ff;
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;

   // input stage only holds off when a decoded item cannot move on
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && out_valid_ff && rsp_stall))
      else $error("req_stall without a blocked item");

   // body bytes only in the body phase
   a_body_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.body_valid) |-> (rsp_data.phase == 2'(hrhp_pkg::PH_BODY)))
      else $error("body byte outside body phase");

   // redirect is reported only as the head ends
   a_redirect_with_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.redirect_seen) |-> rsp_data.headers_done)
      else $error("redirect_seen without headers_done");

   // an error shows only when judged or while failed
   a_error_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.error != hrhp_pkg::ERR_NONE)) |->
      (rsp_data.phase == 2'(hrhp_pkg::PH_FAILED)))
      else $error("error reported outside failed phase");

   // a decoded item always reaches the result register
   a_item_moves: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("decoded item lost");

endmodule

>>> bench/testbench.sv
// testbench: self-checking bench for http_response_head_parser_top, one item per byte
// depends on hrhp_pkg and http_response_head_parser_top; predicts every result item
// from its own parser state and checks it field by field against the result channel
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] VERSION_TAG = "HTTP/1.0";
   localparam logic [63:0] CODE_MAX = (64'd1 << hrhp_pkg::CODE_WIDTH) - 64'd1;
   localparam logic [39:0] BLANK_SET = {hrhp_pkg::CH_SPACE, hrhp_pkg::CH_TAB, 8'h0b, 8'h0c,
                                        hrhp_pkg::CH_CR};
   localparam int RANDOM_ITEMS = 1000;
   localparam int QUIET_TAIL = 150;
   localparam int LONG_HOLD = 60;
   localparam int HOLD_AFTER = 300;
   localparam int REPORT_CAP = 40;

   typedef enum int {
      SHAPE_GOOD,
      SHAPE_BAD_VERSION,
      SHAPE_SHORT,
      SHAPE_NO_CODE,
      SHAPE_BAD_END,
      SHAPE_HUGE_CODE,
      SHAPE_NOISE
   } shape_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   hrhp_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   hrhp_pkg::rsp_type rsp_data;

   // bytes waiting to be offered and result items still to come
   hrhp_pkg::req_type byte_stream[$];
   hrhp_pkg::rsp_type predicted_rsp[$];
   logic restart_next = 1'b0;

   int failures = 0;
   int total_items = 0;
   int taken_items = 0;
   int results_seen = 0;
   int gap_left = 0;
   int hold_left = 0;
   int sender_gap_pct = 8;
   int receiver_gap_pct = 8;
   logic held_long = 1'b0;

   // parser state of the predictor
   hrhp_pkg::phase_type st_phase;
   logic [3:0] st_pos;
   logic st_prefix_ok;
   logic [hrhp_pkg::CODE_WIDTH-1:0] st_code;
   logic st_digits;
   hrhp_pkg::term_type st_term;
   logic st_ovf;
   logic st_cr_line;
   logic [1:0] st_class;

   http_response_head_parser_top uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   function automatic void clear_parse_state();
      st_phase = hrhp_pkg::PH_STATUS;
      st_pos = '0;
      st_prefix_ok = 1'b1;
      st_code = '0;
      st_digits = 1'b0;
      st_term = hrhp_pkg::TERM_SCAN;
      st_ovf = 1'b0;
      st_cr_line = 1'b0;
      st_class = hrhp_pkg::CLASS_OTHER;
   endfunction

   // verdict on the status line, bad version first, then bad code, then overflow
   function automatic logic [1:0] status_verdict();
      if (!st_prefix_ok || st_pos < hrhp_pkg::POS_VERSION) return hrhp_pkg::ERR_VERSION;
      if (st_term != hrhp_pkg::TERM_SPACE) return hrhp_pkg::ERR_MALFORMED;
      if (st_ovf) return hrhp_pkg::ERR_OVERFLOW;
      return hrhp_pkg::ERR_NONE;
   endfunction

   // advance the parser by one byte and return the result item it gives
   function automatic hrhp_pkg::rsp_type parse_byte(input hrhp_pkg::req_type item);
      hrhp_pkg::rsp_type r;
      logic [7:0] b;
      logic [63:0] acc;
      logic [63:0] digit;
      int p;
      r = '0;
      b = item.data_byte;
      if (item.new_response) clear_parse_state();
      case (st_phase)
         hrhp_pkg::PH_STATUS: begin
            if (b == hrhp_pkg::CH_LF) begin
               r.status_done = 1'b1;
               r.error = status_verdict();
               if (r.error != hrhp_pkg::ERR_NONE) begin
                  st_phase = hrhp_pkg::PH_FAILED;
               end else begin
                  acc = 64'(st_code) / 64'd100;
                  st_class = (acc == 64'd2) ? hrhp_pkg::CLASS_SUCCESS :
                             (acc == 64'd3) ? hrhp_pkg::CLASS_REDIRECT : hrhp_pkg::CLASS_OTHER;
                  st_phase = hrhp_pkg::PH_HEADERS;
                  st_pos = '0;
                  st_cr_line = 1'b0;
               end
            end else begin
               p = int'(st_pos);
               if (st_pos < hrhp_pkg::POS_VERSION) begin
                  // last version digit may be either 0 or 1
                  if (b != VERSION_TAG[63 - 8 * p -: 8] &&
                      !(p == 7 && b == hrhp_pkg::CH_ZERO + 8'd1))
                     st_prefix_ok = 1'b0;
               end else if (st_pos >= hrhp_pkg::POS_CODE && st_term == hrhp_pkg::TERM_SCAN) begin
                  if (b >= hrhp_pkg::CH_ZERO && b <= hrhp_pkg::CH_NINE) begin
                     digit = 64'(b - hrhp_pkg::CH_ZERO);
                     acc = 64'(st_code);
                     if (st_ovf || acc > (CODE_MAX - digit) / 64'd10) begin
                        st_ovf = 1'b1;
                        st_code = CODE_MAX[hrhp_pkg::CODE_WIDTH-1:0];
                     end else begin
                        acc = acc * 64'd10 + digit;
                        st_code = acc[hrhp_pkg::CODE_WIDTH-1:0];
                     end
                     st_digits = 1'b1;
                  end else if (!st_digits) begin
                     if (!(b == hrhp_pkg::CH_SPACE ||
                           (b >= hrhp_pkg::CH_TAB && b <= hrhp_pkg::CH_CR)))
                        st_term = hrhp_pkg::TERM_BAD;
                  end else begin
                     st_term = (b == hrhp_pkg::CH_SPACE) ? hrhp_pkg::TERM_SPACE
                                                         : hrhp_pkg::TERM_BAD;
                  end
               end
               if (st_pos < hrhp_pkg::POS_MAX) st_pos = st_pos + 4'd1;
            end
         end
         hrhp_pkg::PH_HEADERS: begin
            if (b == hrhp_pkg::CH_LF) begin
               // a line that opens with cr ends the head, a bare lf does not
               if (st_pos > 4'd0 && st_cr_line) begin
                  st_phase = hrhp_pkg::PH_BODY;
                  r.headers_done = 1'b1;
                  r.redirect_seen = (st_class == hrhp_pkg::CLASS_REDIRECT);
               end
               st_pos = '0;
               st_cr_line = 1'b0;
            end else begin
               if (st_pos == 4'd0) st_cr_line = (b == hrhp_pkg::CH_CR);
               if (st_pos < hrhp_pkg::POS_MAX) st_pos = st_pos + 4'd1;
            end
         end
         hrhp_pkg::PH_BODY: begin
            if (st_class != hrhp_pkg::CLASS_REDIRECT) begin
               r.body_valid = 1'b1;
               r.body_out = b;
            end
         end
         default: ;
      endcase
      if (st_phase == hrhp_pkg::PH_FAILED) r.error = status_verdict();
      r.phase = st_phase;
      if (st_phase == hrhp_pkg::PH_HEADERS || st_phase == hrhp_pkg::PH_BODY) begin
         r.status_code = st_code;
         r.status_class = st_class;
      end
      return r;
   endfunction

   function automatic logic [7:0] random_byte_not(input logic [7:0] x, input logic [7:0] y);
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == x || b == y);
      return b;
   endfunction

   function automatic int pick_gap_pct();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 8;
         default: return 30;
      endcase
   endfunction

   task automatic push_byte(input logic [7:0] b, input logic restart);
      hrhp_pkg::req_type item;
      item.data_byte = b;
      item.new_response = restart | restart_next;
      restart_next = 1'b0;
      byte_stream.push_back(item);
   endtask

   task automatic push_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
   endtask

   // one whole response, well formed or broken in one chosen way
   task automatic queue_response();
      shape_type shape;
      int pick;
      int n;
      int i;
      int cut;
      logic version;
      logic straight_lf;
      logic [7:0] b;
      logic [63:0] code;
      pick = $urandom_range(0, 99);
      shape = pick < 55 ? SHAPE_GOOD : pick < 63 ? SHAPE_BAD_VERSION :
              pick < 70 ? SHAPE_SHORT : pick < 78 ? SHAPE_NO_CODE :
              pick < 86 ? SHAPE_BAD_END : pick < 94 ? SHAPE_HUGE_CODE : SHAPE_NOISE;
      restart_next = 1'b1;
      straight_lf = 1'b0;

      // noise, with restarts scattered through it
      if (shape == SHAPE_NOISE) begin
         n = $urandom_range(1, 20);
         for (i = 0; i < n; i++)
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         return;
      end

      // version prefix, possibly cut short or with one byte spoilt
      version = 1'($urandom_range(0, 1));
      cut = (shape == SHAPE_SHORT) ? $urandom_range(0, 8) : 8;
      pick = (shape == SHAPE_BAD_VERSION) ? $urandom_range(0, 7) : 8;
      for (i = 0; i < cut; i++) begin
         b = (i == 7) ? hrhp_pkg::CH_ZERO + 8'(version) : VERSION_TAG[63 - 8 * i -: 8];
         if (i == pick) begin
            b = b ^ 8'($urandom_range(1, 255));
            if (b == hrhp_pkg::CH_LF ||
                (i == 7 && (b == hrhp_pkg::CH_ZERO || b == hrhp_pkg::CH_ZERO + 8'd1)))
               b = 8'hff;
         end
         push_byte(b, 1'b0);
      end

      if (shape == SHAPE_SHORT) begin
         push_byte(hrhp_pkg::CH_LF, 1'b0);
      end else begin
         // separator, then leading blanks
         push_byte($urandom_range(0, 4) == 0 ?
                   random_byte_not(hrhp_pkg::CH_LF, hrhp_pkg::CH_LF) : hrhp_pkg::CH_SPACE,
                   1'b0);
         n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
         for (i = 0; i < n; i++) push_byte(BLANK_SET[8 * $urandom_range(0, 4) +: 8], 1'b0);

         // the status code itself
         case ($urandom_range(0, 9))
            0, 1, 2, 3: code = 64'($urandom_range(200, 299));
            4, 5, 6: code = 64'($urandom_range(300, 399));
            7: code = 64'($urandom_range(0, 999));
            8: code = 64'($urandom);
            default: code = $urandom_range(0, 1) ? CODE_MAX : 64'd0;
         endcase
         if (shape == SHAPE_HUGE_CODE)
            code = $urandom_range(0, 1) ?
                   CODE_MAX + 64'd1 + 64'($urandom_range(0, 99)) :
                   {32'($urandom_range(1, 32'hffff_ffff)), 32'($urandom)};
         if (shape == SHAPE_NO_CODE) begin
            if ($urandom_range(0, 1)) begin
               do b = random_byte_not(hrhp_pkg::CH_LF, hrhp_pkg::CH_SPACE);
               while ((b >= hrhp_pkg::CH_ZERO && b <= hrhp_pkg::CH_NINE) ||
                      (b >= hrhp_pkg::CH_TAB && b <= hrhp_pkg::CH_CR));
               push_byte(b, 1'b0);
            end else begin
               straight_lf = 1'b1;
            end
         end else begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            for (i = 0; i < n; i++) push_byte(hrhp_pkg::CH_ZERO, 1'b0);
            push_text($sformatf("%0d", code));
            if (shape == SHAPE_BAD_END) begin
               if ($urandom_range(0, 1)) begin
                  do b = random_byte_not(hrhp_pkg::CH_LF, hrhp_pkg::CH_SPACE);
                  while (b >= hrhp_pkg::CH_ZERO && b <= hrhp_pkg::CH_NINE);
                  push_byte(b, 1'b0);
               end else begin
                  straight_lf = 1'b1;
               end
            end else begin
               push_byte(hrhp_pkg::CH_SPACE, 1'b0);
            end
         end

         // reason phrase, long enough at times to saturate the position
         if (!straight_lf) begin
            n = $urandom_range(0, 10);
            for (i = 0; i < n; i++)
               push_byte(random_byte_not(hrhp_pkg::CH_LF, hrhp_pkg::CH_LF), 1'b0);
            if ($urandom_range(0, 1)) push_byte(hrhp_pkg::CH_CR, 1'b0);
         end
         push_byte(hrhp_pkg::CH_LF, 1'b0);
      end

      // header lines, the odd empty one among them
      n = $urandom_range(0, 3);
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 5) == 0) begin
            push_byte(hrhp_pkg::CH_LF, 1'b0);
         end else begin
            push_byte(random_byte_not(hrhp_pkg::CH_LF, hrhp_pkg::CH_CR), 1'b0);
            cut = $urandom_range(0, 12);
            for (pick = 0; pick < cut; pick++)
               push_byte(random_byte_not(hrhp_pkg::CH_LF, hrhp_pkg::CH_LF), 1'b0);
            push_byte(hrhp_pkg::CH_LF, 1'b0);
         end
      end

      // line opening with cr that ends the head, then the body
      push_byte(hrhp_pkg::CH_CR, 1'b0);
      if ($urandom_range(0, 4) == 0)
         push_byte(random_byte_not(hrhp_pkg::CH_LF, hrhp_pkg::CH_LF), 1'b0);
      push_byte(hrhp_pkg::CH_LF, 1'b0);
      n = $urandom_range(0, 12);
      for (i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         failures++;
         if (failures <= REPORT_CAP)
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   task automatic compare_rsp(input hrhp_pkg::rsp_type want, input hrhp_pkg::rsp_type got);
      check_field("phase", want.phase, got.phase);
      check_field("body_valid", want.body_valid, got.body_valid);
      check_field("body_out", want.body_out, got.body_out);
      check_field("status_done", want.status_done, got.status_done);
      check_field("status_code", want.status_code, got.status_code);
      check_field("status_class", want.status_class, got.status_class);
      check_field("headers_done", want.headers_done, got.headers_done);
      check_field("redirect_seen", want.redirect_seen, got.redirect_seen);
      check_field("error", want.error, got.error);
   endtask

   // sender: offers queued bytes, idles in bursts, predicts each accepted item
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
         clear_parse_state();
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            predicted_rsp.push_back(parse_byte(req_data));
            taken_items++;
            if (taken_items % 64 == 0) sender_gap_pct = pick_gap_pct();
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (byte_stream.size() > QUIET_TAIL &&
                      $urandom_range(0, 99) < sender_gap_pct) begin
            gap_left = $urandom_range(0, 8);
            req_valid <= 1'b0;
         end else if (byte_stream.size() > 0) begin
            req_data <= byte_stream.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: checks each accepted result item, stalls in bursts and once for long
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_rsp.size() == 0) begin
               failures++;
               if (failures <= REPORT_CAP)
                  $display("%0t ns: result item with nothing expected, expected none, actual %h",
                           $time, rsp_data);
            end else begin
               compare_rsp(predicted_rsp.pop_front(), rsp_data);
            end
            results_seen++;
            if (results_seen % 64 == 0) receiver_gap_pct = pick_gap_pct();
         end
         if (results_seen == HOLD_AFTER && !held_long) begin
            // long hold so the block fills up and stalls its input
            held_long = 1'b1;
            hold_left = LONG_HOLD;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (byte_stream.size() > QUIET_TAIL &&
                      $urandom_range(0, 99) < receiver_gap_pct) begin
            hold_left = $urandom_range(0, 8);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // stimulus, reset and the end of the run
   initial begin
      // redirect with a dropped body byte, a bad version, bytes ignored after failing
      restart_next = 1'b1;
      push_text("HTTP/1.0 301 ");
      push_byte(hrhp_pkg::CH_LF, 1'b0);
      push_byte(hrhp_pkg::CH_CR, 1'b0);
      push_byte(hrhp_pkg::CH_LF, 1'b0);
      push_byte(8'hff, 1'b0);
      push_byte("Q", 1'b1);
      push_byte(hrhp_pkg::CH_LF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hff, 1'b0);
      push_byte(hrhp_pkg::CH_LF, 1'b0);
      while (byte_stream.size() < RANDOM_ITEMS) queue_response();
      total_items = byte_stream.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (taken_items < total_items) @(posedge clock);
      while (predicted_rsp.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // watchdog
   initial begin
      #3_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

>>> sim.f
hdl/hrhp_pkg.sv
hdl/hrhp_core.sv
hdl/http_response_head_parser_top.sv
bench/testbench.sv
